// ===== src/jpgs_pkg.sv =====
// Package for the joint position goal supervisor.
// Holds the item codes, the item structs and the register map; no dependencies.
package jpgs_pkg;

    localparam int unsigned POS_W      = 32;
    localparam int unsigned TOL_W      = 31;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned AGE_W      = 17;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 5;

    localparam logic [2:0] REG_LOWER_LIMIT     = 3'd0;
    localparam logic [2:0] REG_UPPER_LIMIT     = 3'd1;
    localparam logic [2:0] REG_TOLERANCE       = 3'd2;
    localparam logic [2:0] REG_GOAL_TIMEOUT    = 3'd3;
    localparam logic [2:0] REG_STATE_TIMEOUT   = 3'd4;
    localparam logic [2:0] REG_FEEDBACK_PERIOD = 3'd5;
    localparam logic [2:0] REG_COMMAND_PERIOD  = 3'd6;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_GOAL   = 2'd1,
        OP_CANCEL = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        RESP_NONE          = 3'd0,
        RESP_ACCEPTED      = 3'd1,
        RESP_OUT_OF_RANGE  = 3'd2,
        RESP_BUSY          = 3'd3,
        RESP_NO_FRESH      = 3'd4
    } t_resp;

    typedef enum logic [2:0] {
        OUTC_NONE      = 3'd0,
        OUTC_SUCCEEDED = 3'd1,
        OUTC_INVALID   = 3'd2,
        OUTC_STALE     = 3'd3,
        OUTC_TIMEOUT   = 3'd4,
        OUTC_CANCELED  = 3'd5
    } t_outcome;

    typedef struct packed {
        t_op                     op;
        logic signed [POS_W-1:0] position;
        logic                    sample_ok;
    } t_in_item;

    typedef struct packed {
        t_resp                   goal_response;
        t_outcome                outcome;
        logic signed [POS_W-1:0] final_pos;
        logic                    final_known;
        logic                    feedback_valid;
        logic signed [POS_W-1:0] feedback_target;
        logic signed [POS_W-1:0] feedback_current;
        logic signed [POS_W-1:0] feedback_error;
        logic                    command_valid;
        logic signed [POS_W-1:0] command_position;
    } t_out_item;

endpackage

// ===== src/joint_position_goal_supervisor_core.sv =====
// Top level of the joint position goal supervisor: state, checks and result register.
// Depends on jpgs_pkg for item types, codes and the register map.
//
// Takes one item (sample, goal request, cancel or tick) per clock cycle and gives exactly
// one result item for each, the cycle after acceptance, from a result register. The input
// side stalls only while that register holds a result that the output side stalls. All
// state is updated at the edge that accepts the item; pready is always high. The longest
// path is the 33-bit target-minus-measured subtract and tolerance compare. Registers are
// to be written over APB only while no item is in flight; the block does not enforce it.
module joint_position_goal_supervisor_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  jpgs_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output jpgs_pkg::t_out_item           o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jpgs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [jpgs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [jpgs_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);
    import jpgs_pkg::*;

    localparam logic [AGE_W-1:0]  AGE_MAX = '1;
    localparam logic [TICK_W-1:0] CNT_MAX = '1;

    // configuration
    logic signed [POS_W-1:0] r_lower_limit;
    logic signed [POS_W-1:0] r_upper_limit;
    logic [TOL_W-1:0]        r_tolerance;
    logic [TICK_W-1:0]       r_goal_timeout;
    logic [TICK_W-1:0]       r_state_timeout;
    logic [TICK_W-1:0]       r_feedback_period;
    logic [TICK_W-1:0]       r_command_period;

    // supervisor state
    logic                    r_goal_active,      n_goal_active;
    logic signed [POS_W-1:0] r_goal_target,      n_goal_target;
    logic signed [POS_W-1:0] r_measured_pos,     n_measured_pos;
    logic                    r_measured_valid,   n_measured_valid;
    logic [AGE_W-1:0]        r_sample_age,       n_sample_age;
    logic [AGE_W-1:0]        r_goal_age,         n_goal_age;
    logic                    r_cancel_pending,   n_cancel_pending;
    logic [TICK_W-1:0]       r_feedback_count,   n_feedback_count;
    logic signed [POS_W-1:0] r_hold_command,     n_hold_command;
    logic                    r_hold_valid,       n_hold_valid;
    logic [TICK_W-1:0]       r_command_count,    n_command_count;

    logic                    r_out_valid;
    t_out_item               r_result,           n_result;

    logic                    accept;
    logic                    cfg_write;
    logic [2:0]              cfg_index;
    logic signed [POS_W:0]   diff;
    logic [POS_W:0]          mag;
    logic signed [POS_W-1:0] diff_sat;
    logic                    fresh;

    function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] v);
        return (v == AGE_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [TICK_W-1:0] cnt_inc(input logic [TICK_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = paddr[APB_ADDR_W-1:2];

    always_comb begin
        case (cfg_index)
            REG_LOWER_LIMIT:     prdata = r_lower_limit;
            REG_UPPER_LIMIT:     prdata = r_upper_limit;
            REG_TOLERANCE:       prdata = {1'b0, r_tolerance};
            REG_GOAL_TIMEOUT:    prdata = {{(APB_DATA_W-TICK_W){1'b0}}, r_goal_timeout};
            REG_STATE_TIMEOUT:   prdata = {{(APB_DATA_W-TICK_W){1'b0}}, r_state_timeout};
            REG_FEEDBACK_PERIOD: prdata = {{(APB_DATA_W-TICK_W){1'b0}}, r_feedback_period};
            REG_COMMAND_PERIOD:  prdata = {{(APB_DATA_W-TICK_W){1'b0}}, r_command_period};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_limit     <= {1'b1, {(POS_W-1){1'b0}}};
            r_upper_limit     <= {1'b0, {(POS_W-1){1'b1}}};
            r_tolerance       <= TOL_W'(328);
            r_goal_timeout    <= TICK_W'(300);
            r_state_timeout   <= TICK_W'(30);
            r_feedback_period <= TICK_W'(3);
            r_command_period  <= TICK_W'(2);
        end else if (cfg_write) begin
            case (cfg_index)
                REG_LOWER_LIMIT:     r_lower_limit     <= pwdata;
                REG_UPPER_LIMIT:     r_upper_limit     <= pwdata;
                REG_TOLERANCE:       r_tolerance       <= pwdata[TOL_W-1:0];
                REG_GOAL_TIMEOUT:    r_goal_timeout    <= pwdata[TICK_W-1:0];
                REG_STATE_TIMEOUT:   r_state_timeout   <= pwdata[TICK_W-1:0];
                REG_FEEDBACK_PERIOD: r_feedback_period <= pwdata[TICK_W-1:0];
                REG_COMMAND_PERIOD:  r_command_period  <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign fresh = r_measured_valid && (r_sample_age <= {1'b0, r_state_timeout});

    // arrival distance; the saturated form goes into feedback
    assign diff     = {r_goal_target[POS_W-1], r_goal_target}
                    - {r_measured_pos[POS_W-1], r_measured_pos};
    assign mag      = diff[POS_W] ? (~diff + 1'b1) : diff;
    assign diff_sat = (diff[POS_W] == diff[POS_W-1]) ? diff[POS_W-1:0]
                    : diff[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                  : {1'b0, {(POS_W-1){1'b1}}};

    always_comb begin
        logic end_goal;
        logic end_known;
        logic [TICK_W-1:0] cc;
        end_goal  = 1'b0;
        end_known = 1'b0;
        cc        = '0;

        n_goal_active    = r_goal_active;
        n_goal_target    = r_goal_target;
        n_measured_pos   = r_measured_pos;
        n_measured_valid = r_measured_valid;
        n_sample_age     = r_sample_age;
        n_goal_age       = r_goal_age;
        n_cancel_pending = r_cancel_pending;
        n_feedback_count = r_feedback_count;
        n_hold_command   = r_hold_command;
        n_hold_valid     = r_hold_valid;
        n_command_count  = r_command_count;
        n_result         = '0;

        case (i_in_item.op)
            OP_SAMPLE: begin
                if (i_in_item.sample_ok) begin
                    n_measured_pos   = i_in_item.position;
                    n_measured_valid = 1'b1;
                    n_sample_age     = '0;
                end else begin
                    n_measured_pos   = '0;
                    n_measured_valid = 1'b0;
                end
            end
            OP_GOAL: begin
                if (i_in_item.position < r_lower_limit
                        || i_in_item.position > r_upper_limit) begin
                    n_result.goal_response = RESP_OUT_OF_RANGE;
                end else if (r_goal_active) begin
                    n_result.goal_response = RESP_BUSY;
                end else if (!fresh) begin
                    n_result.goal_response = RESP_NO_FRESH;
                end else begin
                    n_result.goal_response = RESP_ACCEPTED;
                    n_goal_active    = 1'b1;
                    n_goal_target    = i_in_item.position;
                    n_goal_age       = '0;
                    n_cancel_pending = 1'b0;
                    // first check of the goal gives feedback
                    n_feedback_count = CNT_MAX;
                end
            end
            OP_CANCEL: begin
                if (r_goal_active) begin
                    n_cancel_pending = 1'b1;
                end
            end
            default: begin
                // age first, then check the goal with the aged counters
                n_sample_age = age_inc(r_sample_age);
                if (r_goal_active) begin
                    n_goal_age       = age_inc(r_goal_age);
                    n_feedback_count = cnt_inc(r_feedback_count);
                    if (!r_measured_valid) begin
                        end_goal         = 1'b1;
                        n_result.outcome = OUTC_INVALID;
                    end else if (n_sample_age > {1'b0, r_state_timeout}) begin
                        end_goal         = 1'b1;
                        end_known        = 1'b1;
                        n_result.outcome = OUTC_STALE;
                    end else if (n_goal_age > {1'b0, r_goal_timeout}) begin
                        end_goal         = 1'b1;
                        end_known        = 1'b1;
                        n_result.outcome = OUTC_TIMEOUT;
                    end else if (r_cancel_pending) begin
                        end_goal         = 1'b1;
                        end_known        = 1'b1;
                        n_result.outcome = OUTC_CANCELED;
                    end else if (mag <= {2'b00, r_tolerance}) begin
                        end_goal         = 1'b1;
                        end_known        = 1'b1;
                        n_result.outcome = OUTC_SUCCEEDED;
                    end else begin
                        n_hold_command = r_goal_target;
                        n_hold_valid   = 1'b1;
                        if (n_feedback_count >= r_feedback_period) begin
                            n_result.feedback_valid   = 1'b1;
                            n_result.feedback_target  = r_goal_target;
                            n_result.feedback_current = r_measured_pos;
                            n_result.feedback_error   = diff_sat;
                            n_feedback_count          = '0;
                        end
                    end
                    if (end_goal) begin
                        n_result.final_known = end_known;
                        n_result.final_pos   = end_known ? r_measured_pos : '0;
                        n_hold_valid         = end_known;
                        n_hold_command       = end_known ? r_measured_pos : '0;
                        n_goal_active        = 1'b0;
                        n_cancel_pending     = 1'b0;
                    end
                end
                cc = cnt_inc(r_command_count);
                if (cc >= r_command_period) begin
                    cc = '0;
                    if (n_hold_valid) begin
                        n_result.command_valid    = 1'b1;
                        n_result.command_position = n_hold_command;
                    end
                end
                n_command_count = cc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_active    <= 1'b0;
            r_goal_target    <= '0;
            r_measured_pos   <= '0;
            r_measured_valid <= 1'b0;
            r_sample_age     <= AGE_MAX;
            r_goal_age       <= '0;
            r_cancel_pending <= 1'b0;
            r_feedback_count <= '0;
            r_hold_command   <= '0;
            r_hold_valid     <= 1'b0;
            r_command_count  <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (accept) begin
                r_goal_active    <= n_goal_active;
                r_goal_target    <= n_goal_target;
                r_measured_pos   <= n_measured_pos;
                r_measured_valid <= n_measured_valid;
                r_sample_age     <= n_sample_age;
                r_goal_age       <= n_goal_age;
                r_cancel_pending <= n_cancel_pending;
                r_feedback_count <= n_feedback_count;
                r_hold_command   <= n_hold_command;
                r_hold_valid     <= n_hold_valid;
                r_command_count  <= n_command_count;
                r_out_valid      <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

endmodule

// ===== src/jpgs_checker.sv =====
// Port-level checks for the joint position goal supervisor, bound to the top level.
// Depends on jpgs_pkg for the result item type and its codes.
module jpgs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input jpgs_pkg::t_out_item o_result
);
    import jpgs_pkg::*;

    // a stalled result holds
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result))
        else $error("stalled result changed");

    // a goal response comes only from a goal request, never with tick results
    a_resp_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result.goal_response != RESP_NONE
        |-> o_result.outcome == OUTC_NONE && !o_result.feedback_valid
            && !o_result.command_valid)
        else $error("goal response mixed with tick result");

    // an unknown final position reads zero, and only an invalid abort leaves it unknown
    a_final_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result.final_known
        |-> o_result.final_pos == '0
            && (o_result.outcome == OUTC_NONE || o_result.outcome == OUTC_INVALID))
        else $error("final position inconsistent with outcome");

    // feedback only while the goal goes on, and silent fields are zero
    a_feedback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result.feedback_valid |-> o_result.outcome == OUTC_NONE)
        else $error("feedback given with an outcome");

    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result.feedback_valid && !o_result.command_valid
        |-> o_result.feedback_error == '0 && o_result.command_position == '0)
        else $error("unused result fields not zero");

endmodule

bind joint_position_goal_supervisor_core jpgs_checker u_jpgs_checker (.*);
